### hw/rtl/ncpc_pkg.sv
// Shared types and constants of the nearest color point classifier.
package ncpc_pkg;

  localparam int unsigned CLASS_W   = 8;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned COMP_W    = 16;
  localparam int unsigned SQ_W      = 2 * COMP_W;
  localparam int unsigned DIST_W    = 34;
  localparam int unsigned SIZE_W    = 5;
  localparam int unsigned ENTRY_W   = CLASS_W + 3 * COMP_W;

  localparam int unsigned IN_SLOT_LSB  = 0;
  localparam int unsigned IN_RED_LSB   = IN_SLOT_LSB + SLOT_W;
  localparam int unsigned IN_GREEN_LSB = IN_RED_LSB + COMP_W;
  localparam int unsigned IN_BLUE_LSB  = IN_GREEN_LSB + COMP_W;
  localparam int unsigned IN_CLASS_LSB = IN_BLUE_LSB + COMP_W;
  localparam int unsigned IN_TDATA_W   = 64;

  localparam int unsigned OUT_TDATA_W  = 48;
  localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - CLASS_W - SLOT_W - DIST_W;

  typedef enum logic {
    CMD_LOAD     = 1'b0,
    CMD_CLASSIFY = 1'b1
  } cmd_e;

  typedef struct packed {
    logic              wr_en;
    logic              point_ld;
    logic              rd_en;
    logic              rd_first;
    logic [SIZE_W-1:0] rd_idx;
    logic              out_load;
    logic              out_empty;
  } ctl_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/nearest_color_point_classifier.sv
// Top level of the nearest color point classifier.
//
//  channel  dir  tdata (low bit up)                              tuser
//  s_axis   in   entry_index, red, green, blue, class_code, pad  cmd
//  m_axis   out  point_class, nearest_index, distance_sq, pad    no_palette
//  cfg      in   palette_size on cfg_we_i / cfg_wdata_i          -
//
// A load is stored by the palette memory write port on transfer.
// A classify makes one palette memory read per cycle for min(palette_size, PALETTE_DEPTH)
// entries after the transfer, passes through the square and compare stages, then loads the
// result register; with an empty palette it goes from the transfer to the result load.
// A finished result waits in the output register; the next item is taken meanwhile.
// A stalled output holds the scan that follows in its last state until the register frees.
// Reset clears palette_size and the control state; the palette itself is not cleared.
module nearest_color_point_classifier #(
  parameter int unsigned PALETTE_DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // entry_index, red, green, blue, class_code, zero pad
  input  logic [ncpc_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // cmd
  input  logic                             s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // point_class, nearest_index, distance_squared, zero pad
  output logic [ncpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // no_palette
  output logic                             m_axis_tuser_o,
  input  logic                             cfg_we_i,
  input  logic [ncpc_pkg::SIZE_W-1:0]      cfg_wdata_i
);

  ncpc_pkg::ctl_t ctl;
  ncpc_pkg::sts_t sts;

  ncpc_ctrl #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .sts_i           (sts),
    .ctl_o           (ctl)
  );

  ncpc_datapath #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

### hw/rtl/ncpc_datapath.sv
// Palette memory, distance pipeline, running minimum and result register.
module ncpc_datapath #(
  parameter int unsigned PALETTE_DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ncpc_pkg::ctl_t                     ctl_i,
  output ncpc_pkg::sts_t                     sts_o,
  input  logic [ncpc_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [ncpc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  output logic                               m_axis_tuser_o
);

  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [ncpc_pkg::SLOT_W-1:0]  in_slot;
  logic [ncpc_pkg::COMP_W-1:0]  in_red, in_green, in_blue;
  logic [ncpc_pkg::CLASS_W-1:0] in_class;
  logic                         slot_ok;

  logic [ncpc_pkg::ENTRY_W-1:0] mem_q [PALETTE_DEPTH];
  logic [ncpc_pkg::ENTRY_W-1:0] rd_data_q;

  logic [ncpc_pkg::COMP_W-1:0]  pt_red_q, pt_green_q, pt_blue_q;

  logic                         v1_q, first1_q;
  logic [ncpc_pkg::SIZE_W-1:0]  idx1_q;

  logic [ncpc_pkg::COMP_W-1:0]  e_red, e_green, e_blue;
  logic [ncpc_pkg::CLASS_W-1:0] e_class;
  logic [ncpc_pkg::COMP_W-1:0]  ad_red, ad_green, ad_blue;

  logic                         v2_q, first2_q;
  logic [ncpc_pkg::SIZE_W-1:0]  idx2_q;
  logic [ncpc_pkg::CLASS_W-1:0] cls2_q;
  logic [ncpc_pkg::SQ_W-1:0]    sq_red_q, sq_green_q, sq_blue_q;

  logic [ncpc_pkg::DIST_W-1:0]  dist_sum;
  logic                         take_best;
  logic [ncpc_pkg::DIST_W-1:0]  best_dist_q;
  logic [ncpc_pkg::SIZE_W-1:0]  best_idx_q;
  logic [ncpc_pkg::CLASS_W-1:0] best_cls_q;

  logic                         m_valid_q, m_valid_d;
  logic [ncpc_pkg::OUT_TDATA_W-1:0] m_data_q, m_data_d;
  logic                         m_user_q;

  assign in_slot  = s_axis_tdata_i[ncpc_pkg::IN_SLOT_LSB +: ncpc_pkg::SLOT_W];
  assign in_red   = s_axis_tdata_i[ncpc_pkg::IN_RED_LSB +: ncpc_pkg::COMP_W];
  assign in_green = s_axis_tdata_i[ncpc_pkg::IN_GREEN_LSB +: ncpc_pkg::COMP_W];
  assign in_blue  = s_axis_tdata_i[ncpc_pkg::IN_BLUE_LSB +: ncpc_pkg::COMP_W];
  assign in_class = s_axis_tdata_i[ncpc_pkg::IN_CLASS_LSB +: ncpc_pkg::CLASS_W];
  assign slot_ok  = (32'(in_slot) < PALETTE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en && slot_ok) begin
      mem_q[AW'(in_slot)] <= {in_class, in_red, in_green, in_blue};
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[AW'(ctl_i.rd_idx)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.point_ld) begin
      pt_red_q   <= in_red;
      pt_green_q <= in_green;
      pt_blue_q  <= in_blue;
    end
  end

  assign {e_class, e_red, e_green, e_blue} = rd_data_q;
  assign ad_red   = (pt_red_q >= e_red) ? (pt_red_q - e_red) : (e_red - pt_red_q);
  assign ad_green = (pt_green_q >= e_green) ? (pt_green_q - e_green) : (e_green - pt_green_q);
  assign ad_blue  = (pt_blue_q >= e_blue) ? (pt_blue_q - e_blue) : (e_blue - pt_blue_q);

  always_ff @(posedge clk_i) begin
    idx1_q     <= ctl_i.rd_idx;
    first1_q   <= ctl_i.rd_first;
    idx2_q     <= idx1_q;
    first2_q   <= first1_q;
    cls2_q     <= e_class;
    sq_red_q   <= ad_red * ad_red;
    sq_green_q <= ad_green * ad_green;
    sq_blue_q  <= ad_blue * ad_blue;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.rd_en;
      v2_q <= v1_q;
    end
  end

  assign dist_sum = ncpc_pkg::DIST_W'(sq_red_q) + ncpc_pkg::DIST_W'(sq_green_q)
                  + ncpc_pkg::DIST_W'(sq_blue_q);
  assign take_best = v2_q && (first2_q || (dist_sum < best_dist_q));

  always_ff @(posedge clk_i) begin
    if (take_best) begin
      best_dist_q <= dist_sum;
      best_idx_q  <= idx2_q;
      best_cls_q  <= cls2_q;
    end
  end

  assign sts_o.out_free = !m_valid_q || m_axis_tready_i;

  always_comb begin
    m_valid_d = m_valid_q;
    if (ctl_i.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_comb begin
    if (ctl_i.out_empty) begin
      m_data_d = '0;
    end else begin
      m_data_d = {{ncpc_pkg::OUT_PAD_W{1'b0}}, best_dist_q,
                  best_idx_q[ncpc_pkg::SLOT_W-1:0], best_cls_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      m_data_q <= m_data_d;
      m_user_q <= ctl_i.out_empty;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.out_load |-> (!m_valid_q || m_axis_tready_i))
    else $error("result register overwritten while holding a result");

  a_valid_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.rd_en |=> ##1 v2_q)
    else $error("palette read lost in distance pipeline");

  a_first_leads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !first2_q) |-> $past(v2_q))
    else $error("non-first entry compared without a preceding entry");

endmodule

### hw/rtl/ncpc_ctrl.sv
// Controller state machine that sequences loads, palette scans and result hand-off.
module ncpc_ctrl #(
  parameter int unsigned PALETTE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic                          s_axis_tuser_i,
  input  logic                          cfg_we_i,
  input  logic [ncpc_pkg::SIZE_W-1:0]   cfg_wdata_i,
  input  ncpc_pkg::sts_t                sts_i,
  output ncpc_pkg::ctl_t                ctl_o
);

  localparam logic [ncpc_pkg::SIZE_W-1:0] SIZE_LIMIT =
    (PALETTE_DEPTH < (1 << ncpc_pkg::SIZE_W)) ? ncpc_pkg::SIZE_W'(PALETTE_DEPTH)
                                               : {ncpc_pkg::SIZE_W{1'b1}};

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RUN  = 5'b00010,
    ST_DRN1 = 5'b00100,
    ST_DRN2 = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  state_e                      state_q, state_d;
  logic [ncpc_pkg::SIZE_W-1:0] size_q;
  logic [ncpc_pkg::SIZE_W-1:0] count;
  logic [ncpc_pkg::SIZE_W-1:0] k_q, k_d;
  logic                        empty_q, empty_d;
  logic                        accept;
  ncpc_pkg::cmd_e              in_cmd;

  assign count  = (size_q > SIZE_LIMIT) ? SIZE_LIMIT : size_q;
  assign in_cmd = ncpc_pkg::cmd_e'(s_axis_tuser_i);
  assign accept = s_axis_tvalid_i && (state_q == ST_IDLE);
  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    empty_d = empty_q;
    ctl_o   = '0;
    ctl_o.rd_idx    = k_q;
    ctl_o.out_empty = empty_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == ncpc_pkg::CMD_CLASSIFY) begin
            ctl_o.point_ld = 1'b1;
            k_d = '0;
            if (count == '0) begin
              empty_d = 1'b1;
              state_d = ST_FIN;
            end else begin
              empty_d = 1'b0;
              state_d = ST_RUN;
            end
          end else begin
            ctl_o.wr_en = 1'b1;
          end
        end
      end
      ST_RUN: begin
        ctl_o.rd_en    = 1'b1;
        ctl_o.rd_first = (k_q == '0);
        if (k_q == count - ncpc_pkg::SIZE_W'(1)) begin
          state_d = ST_DRN1;
        end else begin
          k_d = k_q + ncpc_pkg::SIZE_W'(1);
        end
      end
      ST_DRN1: begin
        state_d = ST_DRN2;
      end
      ST_DRN2: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      empty_q <= 1'b0;
      size_q  <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      empty_q <= empty_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (k_q < count))
    else $error("palette scan index beyond searched size");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIN) && !sts_i.out_free) |=> (state_q == ST_FIN))
    else $error("result dropped while output stalled");

  a_load_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.wr_en |=> (state_q == ST_IDLE))
    else $error("palette load left the idle state");

  a_empty_no_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIN) && empty_q) |-> !$past(ctl_o.rd_en))
    else $error("empty result after a palette scan");

endmodule

### bench/tb_top.sv
// Self-checking bench for the nearest color point classifier: directed and random stream traffic.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CLASS_W      = ncpc_pkg::CLASS_W;
  localparam int unsigned SLOT_W       = ncpc_pkg::SLOT_W;
  localparam int unsigned COMP_W       = ncpc_pkg::COMP_W;
  localparam int unsigned SQ_W         = ncpc_pkg::SQ_W;
  localparam int unsigned DIST_W       = ncpc_pkg::DIST_W;
  localparam int unsigned SIZE_W       = ncpc_pkg::SIZE_W;
  localparam int unsigned IN_TDATA_W   = ncpc_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W  = ncpc_pkg::OUT_TDATA_W;
  localparam int unsigned IN_SLOT_LSB  = ncpc_pkg::IN_SLOT_LSB;
  localparam int unsigned IN_RED_LSB   = ncpc_pkg::IN_RED_LSB;
  localparam int unsigned IN_GREEN_LSB = ncpc_pkg::IN_GREEN_LSB;
  localparam int unsigned IN_BLUE_LSB  = ncpc_pkg::IN_BLUE_LSB;
  localparam int unsigned IN_CLASS_LSB = ncpc_pkg::IN_CLASS_LSB;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned SETTLE      = 40;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PER_PHASE   = 150;

  localparam int unsigned OUT_CLASS_LSB = 0;
  localparam int unsigned OUT_IDX_LSB   = OUT_CLASS_LSB + CLASS_W;
  localparam int unsigned OUT_DIST_LSB  = OUT_IDX_LSB + SLOT_W;

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [SLOT_W-1:0]  idx;
    logic [DIST_W-1:0]  sqdist;
    logic               empty;
  } match_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_valid;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_data;
  logic                   s_user;
  logic                   m_axis_tvalid_o;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;
  logic                   cfg_we;
  logic [SIZE_W-1:0]      cfg_wdata;

  logic [COMP_W-1:0]  pal_r   [DEPTH];
  logic [COMP_W-1:0]  pal_g   [DEPTH];
  logic [COMP_W-1:0]  pal_b   [DEPTH];
  logic [CLASS_W-1:0] pal_cls [DEPTH];
  logic [SIZE_W-1:0]  size_q = '0;
  match_t             pending_matches[$];
  match_t             exp_m;
  match_t             got_m;

  int  err_cnt    = 0;
  int  n_load     = 0;
  int  n_classify = 0;
  int  n_empty    = 0;
  int  n_checked  = 0;
  int  stall_cnt  = 0;
  int  hold_left  = 0;
  bit  hold_req   = 1'b0;
  bit  hold_seen  = 1'b0;
  bit  src_idle_en;
  bit  snk_idle_en;

  nearest_color_point_classifier #(
    .PALETTE_DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a, b);
    logic [COMP_W-1:0] dlt;
    dlt = (a >= b) ? a - b : b - a;
    return SQ_W'(dlt) * SQ_W'(dlt);
  endfunction

  function automatic match_t nearest_match(input logic [COMP_W-1:0] r, g, b);
    match_t m;
    int unsigned n;
    logic [DIST_W-1:0] d;
    m = '0;
    n = (size_q > SIZE_W'(DEPTH)) ? DEPTH : 32'(size_q);
    if (n == 0) begin
      m.empty = 1'b1;
      return m;
    end
    for (int k = 0; k < n; k++) begin
      d = DIST_W'(sq_diff(r, pal_r[k])) + DIST_W'(sq_diff(g, pal_g[k]))
        + DIST_W'(sq_diff(b, pal_b[k]));
      if (k == 0 || d < m.sqdist) begin
        m.sqdist = d;
        m.idx    = SLOT_W'(k);
        m.cls    = pal_cls[k];
      end
    end
    return m;
  endfunction

  function automatic logic [COMP_W-1:0] rand_comp();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return COMP_W'($urandom);
  endfunction

  // Input side: track the palette and the size register, predict each classify.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) begin
        size_q = cfg_wdata;
      end
      if (s_valid && s_axis_tready_o) begin
        if (ncpc_pkg::cmd_e'(s_user) == ncpc_pkg::CMD_CLASSIFY) begin
          pending_matches.push_back(nearest_match(s_data[IN_RED_LSB +: COMP_W],
                                                  s_data[IN_GREEN_LSB +: COMP_W],
                                                  s_data[IN_BLUE_LSB +: COMP_W]));
          n_classify++;
        end else begin
          pal_r[s_data[IN_SLOT_LSB +: SLOT_W]]   = s_data[IN_RED_LSB +: COMP_W];
          pal_g[s_data[IN_SLOT_LSB +: SLOT_W]]   = s_data[IN_GREEN_LSB +: COMP_W];
          pal_b[s_data[IN_SLOT_LSB +: SLOT_W]]   = s_data[IN_BLUE_LSB +: COMP_W];
          pal_cls[s_data[IN_SLOT_LSB +: SLOT_W]] = s_data[IN_CLASS_LSB +: CLASS_W];
          n_load++;
        end
      end
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
      end
    end
  end

  // Output side: compare each transfer with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got_m.cls    = m_axis_tdata_o[OUT_CLASS_LSB +: CLASS_W];
      got_m.idx    = m_axis_tdata_o[OUT_IDX_LSB +: SLOT_W];
      got_m.sqdist = m_axis_tdata_o[OUT_DIST_LSB +: DIST_W];
      got_m.empty  = m_axis_tuser_o;
      if (pending_matches.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual class %0d index %0d sq %0d",
                 $time, got_m.cls, got_m.idx, got_m.sqdist);
        err_cnt++;
      end else begin
        exp_m = pending_matches.pop_front();
        n_checked++;
        if (exp_m.empty) n_empty++;
        if (got_m.cls !== exp_m.cls) begin
          $display("%0t: point_class expected %0d actual %0d", $time, exp_m.cls, got_m.cls);
          err_cnt++;
        end
        if (got_m.idx !== exp_m.idx) begin
          $display("%0t: nearest_index expected %0d actual %0d", $time, exp_m.idx, got_m.idx);
          err_cnt++;
        end
        if (got_m.sqdist !== exp_m.sqdist) begin
          $display("%0t: distance_squared expected %0d actual %0d",
                   $time, exp_m.sqdist, got_m.sqdist);
          err_cnt++;
        end
        if (got_m.empty !== exp_m.empty) begin
          $display("%0t: no_palette expected %0b actual %0b", $time, exp_m.empty, got_m.empty);
          err_cnt++;
        end
      end
    end
  end

  // Hold off the receiver for a long stretch on request.
  always @(negedge clk_i) begin
    if (hold_req && !hold_seen) begin
      hold_left = HOLD_CYCLES;
    end
    hold_seen = hold_req;
    if (hold_left > 0) begin
      m_ready = 1'b0;
      hold_left--;
    end else begin
      m_ready = !(snk_idle_en && $urandom_range(0, 99) < 20);
    end
  end

  initial begin : watchdog
    while (stall_cnt < STALL_LIMIT) @(posedge clk_i);
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_item(input ncpc_pkg::cmd_e cmd, input logic [SLOT_W-1:0] slot,
                           input logic [COMP_W-1:0] r, g, b, input logic [CLASS_W-1:0] cls);
    while (src_idle_en && $urandom_range(0, 99) < 20) begin
      s_valid = 1'b0;
      @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_user  = cmd;
    s_data  = {4'b0, cls, b, g, r, slot};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  task automatic load_entry(input logic [SLOT_W-1:0] slot, input logic [COMP_W-1:0] r, g, b,
                            input logic [CLASS_W-1:0] cls);
    send_item(ncpc_pkg::CMD_LOAD, slot, r, g, b, cls);
  endtask

  task automatic classify_point(input logic [COMP_W-1:0] r, g, b);
    send_item(ncpc_pkg::CMD_CLASSIFY, SLOT_W'($urandom), r, g, b, CLASS_W'($urandom));
  endtask

  task automatic drain_results();
    s_valid = 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] value);
    drain_results();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  task automatic test_empty_palette();
    classify_point('0, '0, '0);
    classify_point('1, '1, '1);
  endtask

  task automatic test_palette_load();
    for (int k = 0; k < DEPTH; k++) begin
      load_entry(SLOT_W'(k), COMP_W'(k * 4369), COMP_W'(65535 - k * 4369),
                 (k % 2 == 1) ? '1 : '0, CLASS_W'(k * 17));
    end
  endtask

  task automatic test_single_entry();
    write_size(SIZE_W'(1));
    classify_point('1, '0, '1);
  endtask

  task automatic test_full_palette();
    write_size(SIZE_W'(DEPTH));
    classify_point(pal_r[7], pal_g[7], pal_b[7]);
    classify_point('0, '0, '0);
  endtask

  task automatic test_equal_distances();
    load_entry(SLOT_W'(12), pal_r[5], pal_g[5], pal_b[5], 8'hA5);
    classify_point(pal_r[5], pal_g[5], pal_b[5]);
  endtask

  task automatic test_oversized_size();
    write_size('1);
    classify_point(pal_r[15], pal_g[15], pal_b[15]);
  endtask

  task automatic send_random_item();
    logic [COMP_W-1:0] r;
    logic [COMP_W-1:0] g;
    logic [COMP_W-1:0] b;
    int unsigned k;
    int unsigned n;
    n = (size_q > SIZE_W'(DEPTH)) ? DEPTH : 32'(size_q);
    if ($urandom_range(0, 99) < 30) begin
      if ($urandom_range(0, 4) == 0) begin
        k = $urandom_range(0, DEPTH - 1);
        r = pal_r[k];
        g = pal_g[k];
        b = pal_b[k];
      end else begin
        r = rand_comp();
        g = rand_comp();
        b = rand_comp();
      end
      load_entry(SLOT_W'($urandom), r, g, b, CLASS_W'($urandom));
    end else begin
      if (n != 0 && $urandom_range(0, 99) < 40) begin
        k = $urandom_range(0, n - 1);
        r = pal_r[k] + COMP_W'($urandom_range(0, 8)) - COMP_W'(4);
        g = pal_g[k] + COMP_W'($urandom_range(0, 8)) - COMP_W'(4);
        b = pal_b[k] + COMP_W'($urandom_range(0, 8)) - COMP_W'(4);
      end else begin
        r = rand_comp();
        g = rand_comp();
        b = rand_comp();
      end
      classify_point(r, g, b);
    end
  endtask

  task automatic test_random_phases();
    logic [SIZE_W-1:0] sz;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          sz = SIZE_W'(DEPTH);
        end
        1: begin
          sz = '0;
        end
        2: begin
          sz = SIZE_W'(1);
        end
        default: begin
          sz = SIZE_W'($urandom_range(0, DEPTH));
        end
      endcase
      write_size(sz);
      src_idle_en = (p != 3);
      snk_idle_en = (p != 3);
      for (int i = 0; i < PER_PHASE; i++) begin
        send_random_item();
      end
    end
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
  endtask

  task automatic test_output_stall();
    write_size(SIZE_W'(DEPTH));
    src_idle_en = 1'b0;
    hold_req    = 1'b1;
    for (int i = 0; i < 20; i++) begin
      classify_point(rand_comp(), rand_comp(), rand_comp());
    end
    src_idle_en = 1'b1;
  endtask

  initial begin
    rst_ni      = 1'b0;
    s_valid     = 1'b0;
    s_data      = '0;
    s_user      = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_palette();
    test_palette_load();
    test_single_entry();
    test_full_palette();
    test_equal_distances();
    test_oversized_size();
    test_random_phases();
    test_output_stall();
    drain_results();

    $display("Run covered %0d palette loads and %0d classified points (%0d on an empty palette),",
             n_load, n_classify, n_empty);
    $display("%0d results checked over sizes 0 to 16, an oversized size and a long output stall.",
             n_checked);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
